### rtl/core/fp64rti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fp64rti_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_ABS   = 2'd0;
    localparam op_t OP_TRUNC = 2'd1;
    localparam op_t OP_FLOOR = 2'd2;
    localparam op_t OP_CEIL  = 2'd3;

    localparam int EXP_W  = 11;
    localparam int FRAC_W = 52;
    localparam int WORD_W = 64;

    localparam logic [WORD_W-1:0] QNAN_CANON = 64'h7ff8_0000_0000_0000;
    localparam logic [WORD_W-1:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] POS_ONE    = 64'h3ff0_0000_0000_0000;
    localparam logic [WORD_W-1:0] NEG_ONE    = 64'hbff0_0000_0000_0000;

    localparam logic [EXP_W-1:0] EXP_BIAS     = 11'd1023;
    localparam logic [EXP_W-1:0] EXP_MAX      = 11'h7ff;
    localparam logic [EXP_W-1:0] EXP_INTEGRAL = 11'd1075;

endpackage

`default_nettype wire

### rtl/core/fp64_round_to_integral_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary64 absolute value, truncate, floor and ceiling on raw bit patterns.
// A word is taken on every clock edge with start high; busy is always low, so
// a new word may follow in every cycle. Each result appears on result_bits with
// done high for exactly one cycle, in order: it passes the input register, then
// the rounding logic into the result register. The receiver cannot stall and
// must take each result when done is high. Any NaN gives the canonical quiet
// NaN 0x7ff8000000000000.

module fp64_round_to_integral_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire fp64rti_pkg::op_t op,
    input  wire logic [63:0]    operand_bits,
    output logic                done,
    output logic [63:0]         result_bits
);
    import fp64rti_pkg::*;

    logic              in_valid_reg;
    op_t               op_reg;
    logic [WORD_W-1:0] operand_reg;
    logic              done_reg;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg      <= op;
            operand_reg <= operand_bits;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    fp64rti_round u_round
    (
        .op           (op_reg),
        .operand_bits (operand_reg),
        .result_bits  (result_next)
    );

    assign done        = done_reg;
    assign result_bits = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result word not delivered two cycles after start");

    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        done && result_bits[62:52] == EXP_MAX && result_bits[51:0] != '0
        |-> result_bits == QNAN_CANON)
        else $error("non-canonical nan on result");

    a_abs_sign: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && op_reg == OP_ABS |=> !result_bits[63])
        else $error("absolute value left sign set");

    a_integral_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && op_reg != OP_ABS && operand_reg[62:52] >= EXP_INTEGRAL
        && operand_reg[62:52] != EXP_MAX
        |=> result_bits == $past(operand_reg))
        else $error("integral operand altered");

endmodule

`default_nettype wire

### rtl/core/fp64rti_round.sv
`timescale 1ns / 1ps
`default_nettype none

module fp64rti_round
(
    input  wire fp64rti_pkg::op_t op,
    input  wire logic [63:0]    operand_bits,
    output logic [63:0]         result_bits
);
    import fp64rti_pkg::*;

    logic [EXP_W-1:0]  exp_field;
    logic [FRAC_W-1:0] frac_field;
    logic              neg;
    logic [WORD_W-1:0] mag;
    logic [EXP_W-1:0]  shift_full;
    logic [5:0]        shift;
    logic [WORD_W-1:0] bump;
    logic [WORD_W-1:0] below;
    logic [WORD_W-1:0] kept;
    logic              round_up;

    assign exp_field  = operand_bits[62:52];
    assign frac_field = operand_bits[51:0];
    assign neg        = operand_bits[63];
    assign mag        = operand_bits & ~SIGN_BIT;

    // distance from the binary point to the lsb, 1..52 where used
    assign shift_full = EXP_INTEGRAL - exp_field;
    assign shift      = shift_full[5:0];
    assign bump       = WORD_W'(1) << shift;
    assign below      = bump - WORD_W'(1);
    assign kept       = operand_bits & ~below;
    assign round_up   = (op == OP_FLOOR && neg) || (op == OP_CEIL && !neg);

    always_comb
    begin
        if (exp_field == EXP_MAX && frac_field != '0)
        begin
            result_bits = QNAN_CANON;
        end
        else if (op == OP_ABS)
        begin
            result_bits = mag;
        end
        else if (mag == '0 || exp_field == EXP_MAX)
        begin
            result_bits = operand_bits;
        end
        else if (exp_field < EXP_BIAS)
        begin
            unique case (op)
                OP_TRUNC: result_bits = operand_bits & SIGN_BIT;
                OP_FLOOR: result_bits = neg ? NEG_ONE : '0;
                default:  result_bits = neg ? SIGN_BIT : POS_ONE;
            endcase
        end
        else if (exp_field >= EXP_INTEGRAL)
        begin
            result_bits = operand_bits;
        end
        else if ((operand_bits & below) == '0)
        begin
            result_bits = operand_bits;
        end
        else if (round_up)
        begin
            // carry may ripple into the exponent
            result_bits = kept + bump;
        end
        else
        begin
            result_bits = kept;
        end
    end

endmodule

`default_nettype wire
